FILE: rtl/core/bsrs_pkg.sv
// ----------------------------------------------------------------------------
// bsrs_pkg
// Shared types for the blocked sequence range spread block: request modes and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bsrs_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND  = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_ERASE   = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_e;

  // One strobe per datapath operation; dir_dn selects a newest-first slot walk.
  typedef struct packed {
    logic load;
    logic restart;
    logic sum_rd;
    logic app_commit;
    logic e_init;
    logic q_init;
    logic blk_up;
    logic blk_dn;
    logic e_skip;
    logic scan_init;
    logic slot_rd;
    logic dir_dn;
    logic e_eval;
    logic e_commit;
    logic q_merge;
    logic q_eval;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic live_zero;
    logic before_first;
    logic past_last;
    logic blk_at_newest;
    logic blk_zero;
    logic k_ge_live;
    logic k_zero;
    logic cnt_at_used;
    logic cnt_zero;
    logic erase_none;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/core/blocked_sequence_range_spread.sv
// ----------------------------------------------------------------------------
// blocked_sequence_range_spread
// Ordered value store kept in fixed-size blocks with cached per-block min,
// max and live counts; answers max minus min over the newest K live values.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  -------  ---------  ----------------------  ---------------------------------
//  in       request    in_valid_i / in_ready_o mode, value, batch_last,
//                                              first_pos, last_pos, newest_count
//  out      result     out_valid_o/out_ready_i spread, empty_res, full_res
//
// An append reads the newest block summary and then commits; a restart clears the
// store before those steps. An erase or a query reads each block summary it
// visits, decides on it and steps to the next block; a scanned block is read one
// slot at a time through the slot memory's single read port, and an erase ends
// each scanned block with a summary commit. A query scans at most one block; an
// erase scans every block its rank range touches.
// Reset leaves the store empty at once; block summaries carry valid bits and
// slot presence is only read below a block's used count, so no clearing pass
// is needed. A query result waits in the output register; the next request is
// taken only after that register has been loaded.
//
module blocked_sequence_range_spread #(
  parameter int BLOCK_SIZE = 64,
  parameter int NUM_BLOCKS = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] value_i,
  input  logic        batch_last_i,
  input  logic [12:0] first_pos_i,
  input  logic [12:0] last_pos_i,
  input  logic [12:0] newest_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] spread_o,
  output logic        empty_res_o,
  output logic        full_res_o
);
  import bsrs_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // The batch marker carries no meaning for the store; it is accepted and
  // dropped with the rest of the request.
  logic unused_batch;
  assign unused_batch = batch_last_i;

  bsrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsrs_dp #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .NUM_BLOCKS (NUM_BLOCKS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .value_i        (value_i),
    .first_pos_i    (first_pos_i),
    .last_pos_i     (last_pos_i),
    .newest_count_i (newest_count_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .spread_o       (spread_o),
    .empty_res_o    (empty_res_o),
    .full_res_o     (full_res_o)
  );

endmodule

FILE: rtl/core/bsrs_dp.sv
// ----------------------------------------------------------------------------
// bsrs_dp
// Datapath: slot memory, block summary memory, rank and count registers,
// min/max accumulators and the result register.
// ----------------------------------------------------------------------------
module bsrs_dp #(
  parameter int BLOCK_SIZE = 64,
  parameter int NUM_BLOCKS = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsrs_pkg::cmd_t      cmd_i,
  output bsrs_pkg::status_t   sts_o,
  input  logic [31:0]         value_i,
  input  logic [12:0]         first_pos_i,
  input  logic [12:0]         last_pos_i,
  input  logic [12:0]         newest_count_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [31:0]         spread_o,
  output logic                empty_res_o,
  output logic                full_res_o
);
  import bsrs_pkg::*;

  localparam int VB  = VALUE_BITS;
  localparam int BW  = $clog2(NUM_BLOCKS);
  localparam int LW  = $clog2(BLOCK_SIZE + 1);
  localparam int NS  = NUM_BLOCKS * BLOCK_SIZE;
  localparam int SAW = $clog2(NS);
  localparam int TW  = $clog2(NS + 1);
  localparam int PW  = (TW > 13) ? TW : 13;
  localparam int SMW = 2 * VB + 2 * LW;

  // Memories and their registered read data.
  logic [VB:0]      slot_mem [NS];
  logic [VB:0]      slot_rd_q;
  logic [SAW-1:0]   slot_ra_q;
  logic [SMW-1:0]   sum_mem [NUM_BLOCKS];
  logic [SMW-1:0]   sum_rd_q;
  logic [NUM_BLOCKS-1:0] sval_q;
  logic             sval_rd_q;

  logic [BW-1:0]    newest_q, blk_q;
  logic [TW-1:0]    total_q;
  logic             overflow_q, out_valid_q;
  logic [LW-1:0]    cnt_q, nlive_q;
  logic [PW-1:0]    rank_q, f_q, l_q, k_q;
  logic [LW-1:0]    erased_q;
  logic [VB-1:0]    value_q, lo_q, hi_q, nlo_q, nhi_q;
  logic             empty_q, erase_none_q;
  logic [31:0]      spread_q;
  logic             empty_out_q, full_out_q;

  // Decoded summary; a block never written since restart reads as cleared.
  logic [VB-1:0] s_min, s_max;
  logic [LW-1:0] s_live, s_used;
  always_comb begin
    s_min  = sum_rd_q[SMW-1 -: VB];
    s_max  = sum_rd_q[SMW-VB-1 -: VB];
    s_live = sum_rd_q[2*LW-1 -: LW];
    s_used = sum_rd_q[LW-1:0];
    if (!sval_rd_q) begin
      s_min  = '1;
      s_max  = '0;
      s_live = '0;
      s_used = '0;
    end
  end

  // Input clipping at load.
  logic [PW-1:0] fe, le, ke, te, f_c, l_c, k_c;
  assign fe  = PW'(first_pos_i);
  assign le  = PW'(last_pos_i);
  assign ke  = PW'(newest_count_i);
  assign te  = PW'(total_q);
  assign f_c = (fe == '0) ? PW'(1) : fe;
  assign l_c = (le > te) ? te : le;
  assign k_c = (ke > te) ? te : ke;

  // Slot walk address.
  logic [LW-1:0]  idx;
  logic [SAW-1:0] slot_ra;
  assign idx     = cmd_i.dir_dn ? (cnt_q - LW'(1)) : cnt_q;
  assign slot_ra = SAW'(blk_q) * SAW'(BLOCK_SIZE) + SAW'(idx);

  // Append decisions.
  logic          blk_full, at_last;
  logic [BW-1:0] nb;
  assign blk_full = (s_used == LW'(BLOCK_SIZE));
  assign at_last  = (newest_q == BW'(NUM_BLOCKS - 1));
  assign nb       = newest_q + BW'(1);

  // Erase evaluation of the slot just read.
  logic          s_pres;
  logic [VB-1:0] s_val;
  logic [PW-1:0] rank_n;
  logic          in_range;
  assign s_pres   = slot_rd_q[VB];
  assign s_val    = slot_rd_q[VB-1:0];
  assign rank_n   = rank_q + PW'(1);
  assign in_range = (rank_n >= f_q) && (rank_n <= l_q);

  // Write port muxes.
  logic           slot_we, sum_we;
  logic [SAW-1:0] slot_wa;
  logic [VB:0]    slot_wd;
  logic [BW-1:0]  sum_wa;
  logic [SMW-1:0] sum_wd;
  always_comb begin
    slot_we = 1'b0;
    slot_wa = slot_ra_q;
    slot_wd = {1'b0, s_val};
    sum_we  = 1'b0;
    sum_wa  = blk_q;
    sum_wd  = {nlo_q, nhi_q, nlive_q, s_used};
    if (cmd_i.app_commit) begin
      if (!blk_full) begin
        slot_we = 1'b1;
        slot_wa = SAW'(blk_q) * SAW'(BLOCK_SIZE) + SAW'(s_used);
        slot_wd = {1'b1, value_q};
        sum_we  = 1'b1;
        sum_wd  = {((value_q < s_min) ? value_q : s_min),
                   ((value_q > s_max) ? value_q : s_max),
                   s_live + LW'(1), s_used + LW'(1)};
      end else if (!at_last) begin
        slot_we = 1'b1;
        slot_wa = SAW'(nb) * SAW'(BLOCK_SIZE);
        slot_wd = {1'b1, value_q};
        sum_we  = 1'b1;
        sum_wa  = nb;
        sum_wd  = {value_q, value_q, LW'(1), LW'(1)};
      end
    end else if (cmd_i.e_eval) begin
      slot_we = s_pres && in_range;
    end else if (cmd_i.e_commit) begin
      sum_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (cmd_i.slot_rd) slot_rd_q <= slot_mem[slot_ra];
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    if (cmd_i.sum_rd) begin
      sum_rd_q  <= sum_mem[blk_q];
      sval_rd_q <= sval_q[blk_q];
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sval_q      <= '0;
      newest_q    <= '0;
      total_q     <= '0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.restart) begin
        sval_q     <= '0;
        newest_q   <= '0;
        total_q    <= '0;
        overflow_q <= 1'b0;
      end
      if (sum_we) sval_q[sum_wa] <= 1'b1;
      if (cmd_i.app_commit) begin
        if (blk_full && at_last) begin
          overflow_q <= 1'b1;
        end else begin
          total_q <= total_q + TW'(1);
          if (blk_full) newest_q <= nb;
        end
      end
      if (cmd_i.e_commit) total_q <= total_q - TW'(erased_q);
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q      <= value_i[VB-1:0];
      f_q          <= f_c;
      l_q          <= l_c;
      k_q          <= k_c;
      empty_q      <= (k_c == '0);
      erase_none_q <= (total_q == '0) || (f_c > l_c);
      blk_q        <= newest_q;
    end
    if (cmd_i.restart) blk_q <= '0;
    if (cmd_i.e_init) begin
      blk_q  <= '0;
      rank_q <= '0;
    end
    if (cmd_i.q_init) begin
      blk_q <= newest_q;
      lo_q  <= '1;
      hi_q  <= '0;
    end
    if (cmd_i.blk_up) blk_q <= blk_q + BW'(1);
    if (cmd_i.blk_dn) blk_q <= blk_q - BW'(1);
    if (cmd_i.e_skip) rank_q <= rank_q + PW'(s_live);
    if (cmd_i.scan_init) begin
      cnt_q    <= cmd_i.dir_dn ? s_used : '0;
      nlo_q    <= '1;
      nhi_q    <= '0;
      nlive_q  <= '0;
      erased_q <= '0;
    end
    if (cmd_i.slot_rd) begin
      slot_ra_q <= slot_ra;
      cnt_q     <= cmd_i.dir_dn ? (cnt_q - LW'(1)) : (cnt_q + LW'(1));
    end
    if (cmd_i.e_eval && s_pres) begin
      rank_q <= rank_n;
      if (in_range) begin
        erased_q <= erased_q + LW'(1);
      end else begin
        nlive_q <= nlive_q + LW'(1);
        if (s_val < nlo_q) nlo_q <= s_val;
        if (s_val > nhi_q) nhi_q <= s_val;
      end
    end
    if (cmd_i.q_merge) begin
      if (s_min < lo_q) lo_q <= s_min;
      if (s_max > hi_q) hi_q <= s_max;
      k_q <= k_q - PW'(s_live);
    end
    if (cmd_i.q_eval && s_pres) begin
      if (s_val < lo_q) lo_q <= s_val;
      if (s_val > hi_q) hi_q <= s_val;
      k_q <= k_q - PW'(1);
    end
    if (cmd_i.out_load) begin
      spread_q    <= empty_q ? 32'd0 : 32'(hi_q - lo_q);
      empty_out_q <= empty_q;
      full_out_q  <= overflow_q;
    end
  end

  always_comb begin
    sts_o.live_zero     = (s_live == '0);
    sts_o.before_first  = ((PW + 1)'(rank_q) + (PW + 1)'(s_live)) < (PW + 1)'(f_q);
    sts_o.past_last     = (rank_q >= l_q);
    sts_o.blk_at_newest = (blk_q == newest_q);
    sts_o.blk_zero      = (blk_q == '0);
    sts_o.k_ge_live     = (k_q >= PW'(s_live));
    sts_o.k_zero        = (k_q == '0);
    sts_o.cnt_at_used   = (cnt_q == s_used);
    sts_o.cnt_zero      = (cnt_q == '0);
    sts_o.erase_none    = erase_none_q;
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign spread_o    = spread_q;
  assign empty_res_o = empty_out_q;
  assign full_res_o  = full_out_q;

endmodule

FILE: rtl/core/bsrs_ctrl.sv
// ----------------------------------------------------------------------------
// bsrs_ctrl
// Controller: sequences append, restart, erase and query requests over the
// datapath one operation per cycle, pausing while a finished query waits for the result register.
// ----------------------------------------------------------------------------
module bsrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  bsrs_pkg::status_t sts_i,
  output bsrs_pkg::cmd_t    cmd_o
);
  import bsrs_pkg::*;

  typedef enum logic [16:0] {
    ST_IDLE   = 17'h00001,
    ST_R_CLR  = 17'h00002,
    ST_A_RD   = 17'h00004,
    ST_A_CM   = 17'h00008,
    ST_E_CHK  = 17'h00010,
    ST_E_RD   = 17'h00020,
    ST_E_DEC  = 17'h00040,
    ST_E_NEXT = 17'h00080,
    ST_E_SRD  = 17'h00100,
    ST_E_SEV  = 17'h00200,
    ST_E_CM   = 17'h00400,
    ST_Q_CHK  = 17'h00800,
    ST_Q_RD   = 17'h01000,
    ST_Q_DEC  = 17'h02000,
    ST_Q_NEXT = 17'h04000,
    ST_Q_SRD  = 17'h08000,
    ST_Q_SEV  = 17'h10000
  } state_e;

  state_e state_q, state_d;
  logic   q_out_q, q_out_d;
  mode_e  mode;

  assign mode       = mode_e'(mode_i);
  assign in_ready_o = (state_q == ST_IDLE) && !q_out_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    q_out_d = q_out_q;
    if (q_out_q) begin
      // A finished query waits here until the result register is free.
      if (sts_i.out_free) begin
        cmd_o.out_load = 1'b1;
        q_out_d        = 1'b0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            case (mode)
              MODE_APPEND:  state_d = ST_A_RD;
              MODE_RESTART: state_d = ST_R_CLR;
              MODE_ERASE:   state_d = ST_E_CHK;
              MODE_QUERY:   state_d = ST_Q_CHK;
              default:      state_d = ST_IDLE;
            endcase
          end
        end
        ST_R_CLR: begin
          cmd_o.restart = 1'b1;
          state_d       = ST_A_RD;
        end
        ST_A_RD: begin
          cmd_o.sum_rd = 1'b1;
          state_d      = ST_A_CM;
        end
        ST_A_CM: begin
          cmd_o.app_commit = 1'b1;
          state_d          = ST_IDLE;
        end
        ST_E_CHK: begin
          if (sts_i.erase_none) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.e_init = 1'b1;
            state_d      = ST_E_RD;
          end
        end
        ST_E_RD: begin
          cmd_o.sum_rd = 1'b1;
          state_d      = ST_E_DEC;
        end
        ST_E_DEC: begin
          if (sts_i.live_zero) begin
            state_d = ST_E_NEXT;
          end else if (sts_i.before_first) begin
            cmd_o.e_skip = 1'b1;
            state_d      = ST_E_NEXT;
          end else if (sts_i.past_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = ST_E_SRD;
          end
        end
        ST_E_NEXT: begin
          if (sts_i.blk_at_newest) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.blk_up = 1'b1;
            state_d      = ST_E_RD;
          end
        end
        ST_E_SRD: begin
          if (sts_i.cnt_at_used) begin
            state_d = ST_E_CM;
          end else begin
            cmd_o.slot_rd = 1'b1;
            state_d       = ST_E_SEV;
          end
        end
        ST_E_SEV: begin
          cmd_o.e_eval = 1'b1;
          state_d      = ST_E_SRD;
        end
        ST_E_CM: begin
          cmd_o.e_commit = 1'b1;
          state_d        = ST_E_NEXT;
        end
        ST_Q_CHK: begin
          if (sts_i.k_zero) begin
            q_out_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            cmd_o.q_init = 1'b1;
            state_d      = ST_Q_RD;
          end
        end
        ST_Q_RD: begin
          cmd_o.sum_rd = 1'b1;
          state_d      = ST_Q_DEC;
        end
        ST_Q_DEC: begin
          if (sts_i.live_zero) begin
            state_d = ST_Q_NEXT;
          end else if (sts_i.k_ge_live) begin
            cmd_o.q_merge = 1'b1;
            state_d       = ST_Q_NEXT;
          end else begin
            cmd_o.scan_init = 1'b1;
            cmd_o.dir_dn    = 1'b1;
            state_d         = ST_Q_SRD;
          end
        end
        ST_Q_NEXT: begin
          if (sts_i.k_zero || sts_i.blk_zero) begin
            q_out_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            cmd_o.blk_dn = 1'b1;
            state_d      = ST_Q_RD;
          end
        end
        ST_Q_SRD: begin
          if (sts_i.k_zero || sts_i.cnt_zero) begin
            state_d = ST_Q_NEXT;
          end else begin
            cmd_o.slot_rd = 1'b1;
            cmd_o.dir_dn  = 1'b1;
            state_d       = ST_Q_SEV;
          end
        end
        ST_Q_SEV: begin
          cmd_o.q_eval = 1'b1;
          state_d      = ST_Q_SRD;
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      q_out_q <= 1'b0;
    end else begin
      state_q <= state_d;
      q_out_q <= q_out_d;
    end
  end

endmodule
